// ----- rtl/core/account_key_dedup_and_order_core_macros.svh -----
// Assertion macros shared by the core modules
`ifndef ACCOUNT_KEY_DEDUP_AND_ORDER_CORE_MACROS_SVH
`define ACCOUNT_KEY_DEDUP_AND_ORDER_CORE_MACROS_SVH

// check an implication on every clock edge outside reset
`define AKD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check an implication in the cycle after the antecedent
`define AKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/akd_pkg.sv -----
`default_nettype none
package akd_pkg;

    localparam int MaxEntries = 32;
    localparam int IdxW       = $clog2(MaxEntries);
    localparam int CntW       = $clog2(MaxEntries + 1);

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_COMPILE = 2'd1,
        OP_LOOKUP  = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic        wants_signer;
        logic        wants_writable;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  entry_index;
        logic [63:0] out_word0;
        logic [63:0] out_word1;
        logic [63:0] out_word2;
        logic [63:0] out_word3;
        logic        signer_mark;
        logic        writable_mark;
        logic [5:0]  signer_total;
        logic [5:0]  readonly_signer_total;
        logic [5:0]  readonly_plain_total;
        logic        last;
    } t_out;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture request
        logic scan_clr;  // scan index to 0
        logic scan_inc;  // advance scan index
        logic merge;     // OR marks into hit entry
        logic append;    // write new entry at count
        logic clr_cnt;   // count to 0
        logic sort_init; // i=0, j=1
        logic sort_step; // compare/exchange (i,j) and advance
        logic tot_clr;   // clear totals
        logic tot_acc;   // accumulate totals at scan index
        logic emit_key;  // emit entry at scan index
        logic emit_plain;// emit single result
        logic [1:0] plain_status;
        logic plain_hit; // single result carries hit entry
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic [1:0] op;
        logic       hit;       // entry at scan index matches
        logic       scan_end;  // scan index at last valid entry or beyond
        logic       empty;
        logic       full;
        logic       sort_done;
    } t_sts;

endpackage
`default_nettype wire

// ----- rtl/core/akd_datapath.sv -----
`default_nettype none
module akd_datapath
    import akd_pkg::*;
(
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  t_in  i_req,
    input  wire  t_cmd i_cmd,
    output t_sts       o_sts,
    output logic       o_valid,
    output t_out       o_res
);
    `include "account_key_dedup_and_order_core_macros.svh"

    logic [255:0] r_keys [MaxEntries];
    logic [MaxEntries-1:0] r_sig, r_wr;
    logic [CntW-1:0] r_cnt;
    t_in  r_req;
    logic [IdxW-1:0] r_k, r_i, r_j;
    logic r_k_end, r_i_end;
    logic [CntW-1:0] r_st, r_rs, r_rp;
    logic r_valid;
    t_out r_res;

    logic [255:0] w_key;
    logic [1:0] w_pi, w_pj;
    logic w_swap;
    logic w_ro_sig, w_ro_plain;
    t_out w_plain;
    assign w_key = {r_req.key_word3, r_req.key_word2, r_req.key_word1, r_req.key_word0};
    assign w_pi  = {r_sig[r_i], r_wr[r_i]};
    assign w_pj  = {r_sig[r_j], r_wr[r_j]};
    assign w_swap = (w_pj > w_pi);
    assign w_ro_sig   = r_sig[r_k] & ~r_wr[r_k];
    assign w_ro_plain = ~(r_sig[r_k] | r_wr[r_k]);

    // status back to controller
    always_comb begin
        o_sts.op        = r_req.operation;
        o_sts.hit       = (r_keys[r_k] == w_key);
        o_sts.scan_end  = (CntW'(r_k) + CntW'(1) >= r_cnt) || r_k_end;
        o_sts.empty     = (r_cnt == '0);
        o_sts.full      = (r_cnt == CntW'(MaxEntries));
        o_sts.sort_done = (CntW'(r_i) + CntW'(2) > r_cnt) || r_i_end;
    end

    // request capture, count and table updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.append) begin
            r_keys[r_cnt[IdxW-1:0]] <= w_key;
        end
        if (i_cmd.sort_step && w_swap) begin
            r_keys[r_i] <= r_keys[r_j];
            r_keys[r_j] <= r_keys[r_i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_sig[r_cnt[IdxW-1:0]] <= r_req.wants_signer;
            r_wr[r_cnt[IdxW-1:0]]  <= r_req.wants_writable;
        end
        if (i_cmd.merge) begin
            r_sig[r_k] <= r_sig[r_k] | r_req.wants_signer;
            r_wr[r_k]  <= r_wr[r_k] | r_req.wants_writable;
        end
        if (i_cmd.sort_step && w_swap) begin
            r_sig[r_i] <= r_sig[r_j];
            r_sig[r_j] <= r_sig[r_i];
            r_wr[r_i]  <= r_wr[r_j];
            r_wr[r_j]  <= r_wr[r_i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.clr_cnt) begin
            r_cnt <= '0;
        end else if (i_cmd.append) begin
            r_cnt <= r_cnt + CntW'(1);
        end
    end

    // scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_k <= '0;
            r_k_end <= 1'b0;
        end else if (i_cmd.scan_inc) begin
            r_k <= r_k + IdxW'(1);
            r_k_end <= (r_k == IdxW'(MaxEntries - 1));
        end
    end

    // sort indexes: j runs i+1..cnt-1, then i advances
    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_init) begin
            r_i <= '0;
            r_j <= IdxW'(1);
            r_i_end <= 1'b0;
        end else if (i_cmd.sort_step) begin
            if (CntW'(r_j) + CntW'(1) >= r_cnt || r_j == IdxW'(MaxEntries - 1)) begin
                r_i <= r_i + IdxW'(1);
                r_j <= r_i + IdxW'(2);
                r_i_end <= (CntW'(r_i) + CntW'(3) > r_cnt);
            end else begin
                r_j <= r_j + IdxW'(1);
            end
        end
    end

    // header totals
    always_ff @(posedge i_clk) begin
        if (i_cmd.tot_clr) begin
            r_st <= '0;
            r_rs <= '0;
            r_rp <= '0;
        end else if (i_cmd.tot_acc) begin
            r_st <= r_st + CntW'(r_sig[r_k]);
            r_rs <= r_rs + CntW'(w_ro_sig);
            r_rp <= r_rp + CntW'(w_ro_plain);
        end
    end

    // single result: status, plus hit or appended entry
    always_comb begin
        w_plain = '0;
        w_plain.status = i_cmd.plain_status;
        w_plain.last   = 1'b1;
        if (i_cmd.plain_hit) begin
            w_plain.entry_index   = 5'(r_k);
            w_plain.signer_mark   = r_sig[r_k] | (i_cmd.merge & r_req.wants_signer);
            w_plain.writable_mark = r_wr[r_k] | (i_cmd.merge & r_req.wants_writable);
        end else if (i_cmd.append) begin
            w_plain.entry_index   = 5'(r_cnt);
            w_plain.signer_mark   = r_req.wants_signer;
            w_plain.writable_mark = r_req.wants_writable;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_key | i_cmd.emit_plain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_key) begin
            r_res.status      <= ST_OK;
            r_res.entry_index <= 5'(r_k);
            {r_res.out_word3, r_res.out_word2, r_res.out_word1, r_res.out_word0}
                <= r_keys[r_k];
            r_res.signer_mark   <= r_sig[r_k];
            r_res.writable_mark <= r_wr[r_k];
            r_res.signer_total          <= 6'(r_st);
            r_res.readonly_signer_total <= 6'(r_rs);
            r_res.readonly_plain_total  <= 6'(r_rp);
            r_res.last        <= o_sts.scan_end;
        end else if (i_cmd.emit_plain) begin
            r_res <= w_plain;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    `AKD_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CntW'(MaxEntries),
        "entry count past capacity")
    `AKD_ASSERT_IMP(a_no_append_full, i_clk, i_rst_n, i_cmd.append, !o_sts.full,
        "append on a full table")
    `AKD_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, i_cmd.emit_key, r_valid,
        "emitted entry lost")
endmodule
`default_nettype wire

// ----- rtl/core/akd_ctrl.sv -----
`default_nettype none
module akd_ctrl
    import akd_pkg::*;
(
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  logic i_start,
    input  wire  t_sts i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy
);
    `include "account_key_dedup_and_order_core_macros.svh"

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DISP  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SORT  = 6'b001000,
        S_TOT   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (t_op'(i_sts.op))
                    OP_CLEAR: begin
                        o_cmd.clr_cnt = 1'b1;
                        o_cmd.emit_plain = 1'b1;
                        o_cmd.plain_status = ST_OK;
                        n_state = S_IDLE;
                    end
                    OP_COMPILE: begin
                        if (i_sts.empty) begin
                            o_cmd.emit_plain = 1'b1;
                            o_cmd.plain_status = ST_EMPTY;
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.sort_init = 1'b1;
                            n_state = S_SORT;
                        end
                    end
                    default: begin
                        if (i_sts.empty) begin
                            o_cmd.emit_plain = 1'b1;
                            if (i_sts.op == OP_ADD) begin
                                o_cmd.append = 1'b1;
                                o_cmd.plain_status = ST_OK;
                            end else begin
                                o_cmd.plain_status = ST_NOT_FOUND;
                            end
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.emit_plain = 1'b1;
                    o_cmd.plain_status = ST_OK;
                    o_cmd.plain_hit = 1'b1;
                    o_cmd.merge = (i_sts.op == OP_ADD);
                    n_state = S_IDLE;
                end else if (i_sts.scan_end) begin
                    o_cmd.emit_plain = 1'b1;
                    if (i_sts.op == OP_ADD) begin
                        if (i_sts.full) begin
                            o_cmd.plain_status = ST_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                            o_cmd.plain_status = ST_OK;
                        end
                    end else begin
                        o_cmd.plain_status = ST_NOT_FOUND;
                    end
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_SORT: begin
                if (i_sts.sort_done) begin
                    o_cmd.scan_clr = 1'b1;
                    o_cmd.tot_clr = 1'b1;
                    n_state = S_TOT;
                end else begin
                    o_cmd.sort_step = 1'b1;
                end
            end
            S_TOT: begin
                o_cmd.tot_acc = 1'b1;
                if (i_sts.scan_end) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_EMIT: begin
                o_cmd.emit_key = 1'b1;
                if (i_sts.scan_end) n_state = S_IDLE;
                else o_cmd.scan_inc = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    `AKD_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, (r_state == S_IDLE) && i_start,
        o_busy, "accepted transfer did not raise busy")
    `AKD_ASSERT_IMP(a_one_emit, i_clk, i_rst_n, 1'b1,
        !(o_cmd.emit_key && o_cmd.emit_plain), "two results in one cycle")
    `AKD_ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE,
        !o_cmd.emit_key && !o_cmd.sort_step, "work issued while idle")
endmodule
`default_nettype wire

// ----- rtl/core/account_key_dedup_and_order_core.sv -----
// Channel  | Ports                        | Transfer
// ---------+------------------------------+---------------------------------
// request  | i_start, o_busy, i_req       | edge with i_start=1, o_busy=0
// result   | o_done, o_res                | every edge with o_done=1
//
// Add/lookup: the scan walks one stored key a cycle (up to 32).
// Compile: exchange sort over n(n-1)/2 pairs, one pair a cycle, then a totals pass
// and an emit pass over the n keys; clear or empty table: result from dispatch.
// Results are registered and appear in the cycle after their emit command.
// Reset (synchronous, active low) empties the table; key storage is not cleared.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none
module account_key_dedup_and_order_core
    import akd_pkg::*;
(
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  logic i_start,
    input  wire  t_in  i_req,
    output logic       o_busy,
    output logic       o_done,
    output t_out       o_res
);
    t_cmd w_cmd;
    t_sts w_sts;

    akd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(o_busy)
    );

    akd_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_valid(o_done), .o_res(o_res)
    );
endmodule
`default_nettype wire

// ----- tb/account_key_dedup_and_order_core_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module account_key_dedup_and_order_core_tb
    import akd_pkg::*;
();

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_in  i_req;
    logic o_busy;
    logic o_done;
    t_out o_res;

    account_key_dedup_and_order_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // clock, 12 ns period
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the account table
    logic [255:0] acct_key [MaxEntries];
    logic         acct_sig [MaxEntries];
    logic         acct_wr  [MaxEntries];
    int           acct_cnt;

    t_out result_q [$];
    int   mismatch_cnt;
    int   idle_cnt;
    int   sent_cnt;

    // pool of keys so adds and lookups hit often
    logic [255:0] key_pool [48];

    function automatic t_out blank_result(logic [1:0] st);
        t_out r;
        r = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic int find_acct(logic [255:0] k);
        for (int i = 0; i < acct_cnt; i++)
            if (acct_key[i] == k) return i;
        return -1;
    endfunction

    // compute results of one request and update the shadow table
    task automatic predict_request(t_in rq);
        logic [255:0] k;
        int           hit;
        t_out         r;
        logic [255:0] tk;
        logic         ts;
        logic         tw;
        int           sig_n;
        int           ro_sig;
        int           ro_plain;
        k = {rq.key_word3, rq.key_word2, rq.key_word1, rq.key_word0};
        hit = find_acct(k);
        r = blank_result(ST_OK);
        case (t_op'(rq.operation))
            OP_ADD: begin
                if (hit >= 0) begin
                    acct_sig[hit] |= rq.wants_signer;
                    acct_wr[hit]  |= rq.wants_writable;
                    r.entry_index   = hit[4:0];
                    r.signer_mark   = acct_sig[hit];
                    r.writable_mark = acct_wr[hit];
                end else if (acct_cnt >= MaxEntries) begin
                    r.status = ST_FULL;
                end else begin
                    acct_key[acct_cnt] = k;
                    acct_sig[acct_cnt] = rq.wants_signer;
                    acct_wr[acct_cnt]  = rq.wants_writable;
                    r.entry_index   = acct_cnt[4:0];
                    r.signer_mark   = rq.wants_signer;
                    r.writable_mark = rq.wants_writable;
                    acct_cnt++;
                end
                result_q.push_back(r);
            end
            OP_LOOKUP: begin
                if (hit >= 0) begin
                    r.entry_index   = hit[4:0];
                    r.signer_mark   = acct_sig[hit];
                    r.writable_mark = acct_wr[hit];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
                result_q.push_back(r);
            end
            OP_CLEAR: begin
                acct_cnt = 0;
                result_q.push_back(r);
            end
            default: begin
                if (acct_cnt == 0) begin
                    result_q.push_back(blank_result(ST_EMPTY));
                end else begin
                    // exchange sort on priority = signer*2 + writable
                    for (int i = 0; i < acct_cnt; i++)
                        for (int j = i + 1; j < acct_cnt; j++)
                            if ({acct_sig[j], acct_wr[j]} > {acct_sig[i], acct_wr[i]}) begin
                                tk = acct_key[i]; acct_key[i] = acct_key[j]; acct_key[j] = tk;
                                ts = acct_sig[i]; acct_sig[i] = acct_sig[j]; acct_sig[j] = ts;
                                tw = acct_wr[i];  acct_wr[i]  = acct_wr[j];  acct_wr[j]  = tw;
                            end
                    sig_n = 0; ro_sig = 0; ro_plain = 0;
                    for (int i = 0; i < acct_cnt; i++) begin
                        if (acct_sig[i]) begin
                            sig_n++;
                            if (!acct_wr[i]) ro_sig++;
                        end else if (!acct_wr[i]) begin
                            ro_plain++;
                        end
                    end
                    for (int i = 0; i < acct_cnt; i++) begin
                        r = '0;
                        r.status      = ST_OK;
                        r.entry_index = i[4:0];
                        {r.out_word3, r.out_word2, r.out_word1, r.out_word0} = acct_key[i];
                        r.signer_mark   = acct_sig[i];
                        r.writable_mark = acct_wr[i];
                        r.signer_total          = sig_n[5:0];
                        r.readonly_signer_total = ro_sig[5:0];
                        r.readonly_plain_total  = ro_plain[5:0];
                        r.last = (i == acct_cnt - 1);
                        result_q.push_back(r);
                    end
                end
            end
        endcase
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (result_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: %p", o_res);
            end else begin
                if (o_res !== result_q[0]) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp %p\n          got %p", result_q[0], o_res);
                end
                void'(result_q.pop_front());
            end
        end
    end

    // watchdog on cycles without a transfer
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 20000) begin
            $display("account_key_dedup_and_order_core_tb: errors");
            $finish;
        end
    end

    // one request transfer; the item is predicted at the edge it is accepted
    task automatic send_request(t_in rq, bit allow_gap);
        if (allow_gap && $urandom_range(99) < 38) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= rq;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_request(rq);
        sent_cnt++;
    endtask

    function automatic t_in make_request(t_op op, logic [255:0] k, logic s, logic w);
        t_in rq;
        rq.operation = op;
        {rq.key_word3, rq.key_word2, rq.key_word1, rq.key_word0} = k;
        rq.wants_signer   = s;
        rq.wants_writable = w;
        return rq;
    endfunction

    function automatic logic [255:0] rand_key();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // directed rows; a typed-in result is checked on top of the predictor
    typedef struct {
        t_op          op;
        logic [255:0] k;
        logic         s;
        logic         w;
        bit           has_exp;
        logic [1:0]   exp_status;
        logic [4:0]   exp_index;
    } t_row;

    t_row dir_rows [$];
    t_in  rq;
    int   n_rand;
    int   mode;

    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_req        = '0;
        acct_cnt     = 0;
        mismatch_cnt = 0;
        idle_cnt     = 0;
        sent_cnt     = 0;
        for (int i = 0; i < 48; i++) key_pool[i] = rand_key();
        key_pool[0] = '0;
        key_pool[1] = '1;

        dir_rows = '{
            '{OP_COMPILE, '0, 1, 1, 1, ST_EMPTY,     0},
            '{OP_LOOKUP,  '1, 1, 1, 1, ST_NOT_FOUND, 0},
            '{OP_ADD,     '0, 0, 0, 1, ST_OK,        0},
            '{OP_ADD,     '1, 1, 1, 1, ST_OK,        1},
            '{OP_ADD,     key_pool[2], 1, 0, 1, ST_OK, 2},
            '{OP_ADD,     key_pool[3], 0, 1, 1, ST_OK, 3},
            '{OP_ADD,     '0, 0, 1, 1, ST_OK,        0},
            '{OP_ADD,     key_pool[2], 0, 0, 1, ST_OK, 2},
            '{OP_LOOKUP,  '1, 0, 0, 1, ST_OK,        1},
            '{OP_LOOKUP,  key_pool[4], 0, 0, 1, ST_NOT_FOUND, 0},
            '{OP_COMPILE, '1, 1, 1, 0, ST_OK,        0},
            '{OP_COMPILE, '0, 0, 0, 0, ST_OK,        0},
            '{OP_CLEAR,   '1, 1, 1, 1, ST_OK,        0},
            '{OP_COMPILE, '0, 0, 0, 1, ST_EMPTY,     0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_request(make_request(dir_rows[r].op, dir_rows[r].k,
                                      dir_rows[r].s, dir_rows[r].w), 1'b1);
            if (dir_rows[r].has_exp) begin
                if (result_q[$].status !== dir_rows[r].exp_status ||
                    result_q[$].entry_index !== dir_rows[r].exp_index) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("row %0d: exp status %0d index %0d, got status %0d index %0d",
                                 r, dir_rows[r].exp_status, dir_rows[r].exp_index,
                                 result_q[$].status, result_q[$].entry_index);
                end
            end
        end

        // fill the table past capacity to reach the full status
        for (int i = 0; i < MaxEntries + 2; i++)
            send_request(make_request(OP_ADD, rand_key(), 1'($urandom_range(1)),
                                      1'($urandom_range(1))), 1'b0);
        send_request(make_request(OP_COMPILE, '0, 1'b0, 1'b0), 1'b0);
        send_request(make_request(OP_CLEAR, '0, 1'b0, 1'b0), 1'b0);

        // random transactions: clear, payer, accounts, compile; plus noise
        n_rand = 0;
        while (n_rand < 100) begin
            bit no_gap;
            int n_acc;
            no_gap = (n_rand >= 40 && n_rand < 70);
            mode = $urandom_range(9);
            if (mode < 7) begin
                send_request(make_request(OP_CLEAR, rand_key(), 1'($urandom_range(1)),
                                          1'($urandom_range(1))), !no_gap);
                send_request(make_request(OP_ADD, key_pool[$urandom_range(47)], 1'b1, 1'b1),
                             !no_gap);
                n_acc = $urandom_range(1, 8);
                for (int i = 0; i < n_acc; i++)
                    send_request(make_request(t_op'($urandom_range(9) < 8 ? OP_ADD : OP_LOOKUP),
                                              key_pool[$urandom_range(47)],
                                              1'($urandom_range(1)), 1'($urandom_range(1))),
                                 !no_gap);
                send_request(make_request(OP_COMPILE, rand_key(), 1'($urandom_range(1)),
                                          1'($urandom_range(1))), !no_gap);
                n_rand += n_acc + 3;
            end else begin
                rq = make_request(t_op'($urandom_range(3)),
                                  $urandom_range(1) ? key_pool[$urandom_range(47)] : rand_key(),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                send_request(rq, !no_gap);
                n_rand++;
            end
        end
        i_start <= 1'b0;

        while (result_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatch_cnt == 0 && result_q.size() == 0)
            $display("account_key_dedup_and_order_core_tb: clean");
        else
            $display("account_key_dedup_and_order_core_tb: errors");
        $finish;
    end

endmodule
`default_nettype wire
